// ===== rtl/ttta_pkg.sv =====
// ----------------------------------------------------------------------------
// ttta_pkg
// Shared types and constants of the transaction table with id allocation.
// ----------------------------------------------------------------------------
package ttta_pkg;

  localparam int ENTRIES  = 16;
  localparam int SLOT_W   = $clog2(ENTRIES);
  localparam int COUNT_W  = $clog2(ENTRIES + 1);
  localparam int SUB_W    = 16;
  localparam int PROTO_W  = 4;
  localparam int TID_W    = 4;
  localparam int CREF_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;
  localparam int HPOS_W   = 3;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [TID_W-1:0]    tid_t;

  // operation codes
  localparam kind_t K_FIND_ID  = 3'd0;
  localparam kind_t K_FIND_REF = 3'd1;
  localparam kind_t K_ALLOC    = 3'd2;
  localparam kind_t K_FREE     = 3'd3;
  localparam kind_t K_ASSIGN   = 3'd4;

  // result status codes
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_NOT_FOUND = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_NO_ID     = 3'd3;
  localparam status_t ST_UNUSED    = 3'd4;

  // circular id search: ids 0..6, flag adds 8
  localparam logic [HPOS_W-1:0] ID_TOP     = 3'd6;
  localparam logic [HPOS_W-1:0] ID_LOW     = 3'd1;
  localparam logic [HPOS_W-1:0] ID_TRY_MAX = 3'd6;

endpackage

// ===== rtl/transaction_table_tid_allocator.sv =====
// Sequence: accept, a walk over every table entry, then the reply; free reads its entry
// before the walk, and assign id adds a start-point search and a circular id search.
// Throughput: one transfer at a time; a new item is taken once the previous
// result has been loaded into the output register.
// Reset: valid bits and entry count cleared at once, no clearing pass; entry
// payloads are not reset.
// ----------------------------------------------------------------------------
// transaction_table_tid_allocator
// Table of call transactions in insertion order with find, allocate, free
// and circular transaction-id assignment, served by one sequenced compare unit.
// ----------------------------------------------------------------------------
module transaction_table_tid_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ttta_pkg::kind_t                 kind,
  input  logic [ttta_pkg::SUB_W-1:0]      subscriber,
  input  logic [ttta_pkg::PROTO_W-1:0]    protocol,
  input  ttta_pkg::tid_t                  tid,
  input  logic                            tid_assigned,
  input  logic [ttta_pkg::CREF_W-1:0]     call_reference,
  input  logic                            flag_side,
  input  ttta_pkg::slot_t                 slot,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ttta_pkg::status_t               status,
  output ttta_pkg::slot_t                 found_slot,
  output ttta_pkg::tid_t                  result_tid,
  output logic                            result_tid_assigned,
  output logic [ttta_pkg::CREF_W-1:0]     result_call_reference
);
  import ttta_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for an input transfer
  localparam logic [2:0] S_SCAN   = 3'd1;  // walk every entry through the compare unit
  localparam logic [2:0] S_FREE   = 3'd2;  // read the entry being freed
  localparam logic [2:0] S_HSRCH  = 3'd3;  // find the start point of the id search
  localparam logic [2:0] S_IDSRCH = 3'd4;  // circular search for a free id
  localparam logic [2:0] S_REPLY  = 3'd5;  // load the output register

  logic [2:0] state;

  // Entry storage: payloads without reset, valid bits and count with reset
  logic [SUB_W-1:0]   e_sub   [ENTRIES];
  logic [PROTO_W-1:0] e_proto [ENTRIES];
  tid_t               e_tid   [ENTRIES];
  logic               e_tid_as[ENTRIES];
  logic [CREF_W-1:0]  e_cref  [ENTRIES];
  slot_t              e_rank  [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [COUNT_W-1:0] count;

  // Latched operation
  kind_t              op_kind;
  logic [SUB_W-1:0]   op_sub;
  logic [PROTO_W-1:0] op_proto;
  tid_t               op_tid;
  logic               op_tid_as;
  logic [CREF_W-1:0]  op_cref;
  logic               op_flag;
  slot_t              op_slot;

  // Walk state
  slot_t              idx;
  logic               have;
  slot_t              best_rank;
  slot_t              gone;
  logic [(1 << TID_W)-1:0] used;
  logic [HPOS_W-1:0]  hpos;
  logic [HPOS_W-1:0]  tries;

  // Pending result
  status_t            res_status;
  slot_t              res_slot;
  tid_t               res_tid;
  logic               res_tid_as;
  logic [CREF_W-1:0]  res_cref;

  // Shared compare unit: one entry per cycle, at address idx
  logic               rd_valid;
  logic [SUB_W-1:0]   rd_sub;
  logic [PROTO_W-1:0] rd_proto;
  tid_t               rd_tid;
  logic               rd_tid_as;
  logic [CREF_W-1:0]  rd_cref;
  slot_t              rd_rank;
  logic               key_match;
  logic               id_match;
  logic               ref_match;
  logic               hit;
  logic               take;
  logic               last;
  tid_t               cand_id;
  logic               out_load;

  assign rd_valid  = valid[idx];
  assign rd_sub    = e_sub[idx];
  assign rd_proto  = e_proto[idx];
  assign rd_tid    = e_tid[idx];
  assign rd_tid_as = e_tid_as[idx];
  assign rd_cref   = e_cref[idx];
  assign rd_rank   = e_rank[idx];

  assign key_match = rd_valid && (rd_sub == op_sub) && (rd_proto == op_proto);
  assign id_match  = key_match && (rd_tid_as == op_tid_as) &&
                     (!op_tid_as || (rd_tid == op_tid));
  assign ref_match = rd_valid && (rd_cref == op_cref);
  assign last      = (idx == slot_t'(ENTRIES - 1));
  assign cand_id   = {op_flag, hpos};

  always_comb begin
    hit  = 1'b0;
    take = 1'b0;
    case (op_kind)
      K_FIND_ID: begin
        hit  = id_match;
        take = hit && (!have || (rd_rank < best_rank));
      end
      K_FIND_REF: begin
        hit  = ref_match;
        take = hit && (!have || (rd_rank < best_rank));
      end
      K_ALLOC: begin
        // lowest-numbered free slot wins
        hit  = !rd_valid;
        take = hit && !have;
      end
      default: begin
        hit  = 1'b0;
        take = 1'b0;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_REPLY) && (!out_valid || out_ready);

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (kind) inside
              K_FIND_ID, K_FIND_REF, K_ALLOC, K_ASSIGN: state <= S_SCAN;
              K_FREE:                                   state <= S_FREE;
              default:                                  state <= S_REPLY;
            endcase
          end
        end
        S_SCAN: begin
          if (last) begin
            state <= (op_kind == K_ASSIGN) ? S_HSRCH : S_REPLY;
          end
        end
        S_FREE: begin
          if (rd_valid) begin
            // drop the entry now; the walk closes the gap in the ranks
            valid[idx] <= 1'b0;
            if (count != '0) begin
              count <= count - COUNT_W'(1);
            end
            state <= S_SCAN;
          end else begin
            state <= S_REPLY;
          end
        end
        S_HSRCH: begin
          if (used[cand_id] || (hpos == ID_LOW)) begin
            state <= S_IDSRCH;
          end
        end
        S_IDSRCH: begin
          if (!used[cand_id] || (tries == ID_TRY_MAX)) begin
            state <= S_REPLY;
          end
        end
        S_REPLY: begin
          if (out_load) begin
            if ((op_kind == K_ALLOC) && (res_status == ST_OK)) begin
              valid[res_slot] <= 1'b1;
              count           <= count + COUNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Operation latch, walk registers and pending result (no reset needed)
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op_kind    <= kind;
        op_sub     <= subscriber;
        op_proto   <= protocol;
        op_tid     <= tid;
        op_tid_as  <= tid_assigned;
        op_cref    <= call_reference;
        op_flag    <= flag_side;
        op_slot    <= slot;
        idx        <= (kind == K_FREE) ? slot : '0;
        have       <= 1'b0;
        best_rank  <= '0;
        used       <= '0;
        hpos       <= ID_TOP;
        tries      <= '0;
        res_status <= ST_NOT_FOUND;
        res_slot   <= '0;
        res_tid    <= '0;
        res_tid_as <= 1'b0;
        res_cref   <= '0;
      end
      S_SCAN: begin
        idx <= idx + slot_t'(1);
        if (take) begin
          have      <= 1'b1;
          best_rank <= rd_rank;
          res_slot  <= idx;
          res_tid   <= rd_tid;
          res_tid_as <= rd_tid_as;
          res_cref  <= rd_cref;
        end
        if ((op_kind == K_ASSIGN) && key_match && rd_tid_as) begin
          used[rd_tid] <= 1'b1;
        end
        if (last) begin
          case (op_kind) inside
            K_FIND_ID, K_FIND_REF: begin
              res_status <= (have || take) ? ST_OK : ST_NOT_FOUND;
            end
            K_ALLOC: begin
              if (have || take) begin
                res_status <= ST_OK;
                res_tid    <= op_tid;
                res_tid_as <= op_tid_as;
                res_cref   <= op_cref;
              end else begin
                res_status <= ST_FULL;
              end
            end
            default: begin
              // free keeps the result taken at the read; assign id goes on
            end
          endcase
        end
      end
      S_FREE: begin
        res_slot <= op_slot;
        idx      <= '0;
        gone     <= rd_rank;
        if (rd_valid) begin
          res_status <= ST_OK;
          res_tid    <= rd_tid;
          res_tid_as <= rd_tid_as;
          res_cref   <= rd_cref;
        end else begin
          res_status <= ST_UNUSED;
        end
      end
      S_HSRCH: begin
        if (!used[cand_id]) begin
          // no id in use down to 1: start from 0
          hpos <= (hpos == ID_LOW) ? '0 : hpos - HPOS_W'(1);
        end
      end
      S_IDSRCH: begin
        if (!used[cand_id]) begin
          res_status <= ST_OK;
          res_tid    <= cand_id;
          res_tid_as <= 1'b1;
        end else if (tries == ID_TRY_MAX) begin
          res_status <= ST_NO_ID;
        end else begin
          hpos  <= (hpos == ID_TOP) ? '0 : hpos + HPOS_W'(1);
          tries <= tries + HPOS_W'(1);
        end
      end
      S_REPLY: begin
        if (out_load) begin
          status                <= res_status;
          found_slot            <= res_slot;
          result_tid            <= res_tid;
          result_tid_assigned   <= res_tid_as;
          result_call_reference <= res_cref;
        end
      end
      default: begin
      end
    endcase
  end

  // Entry payload writes: rank repair during the free walk, new entry on reply
  always_ff @(posedge clk) begin
    if ((state == S_SCAN) && (op_kind == K_FREE) && rd_valid && (rd_rank > gone)) begin
      e_rank[idx] <= rd_rank - slot_t'(1);
    end
    if (out_load && (op_kind == K_ALLOC) && (res_status == ST_OK)) begin
      e_sub[res_slot]    <= op_sub;
      e_proto[res_slot]  <= op_proto;
      e_tid[res_slot]    <= op_tid;
      e_tid_as[res_slot] <= op_tid_as;
      e_cref[res_slot]   <= op_cref;
      e_rank[res_slot]   <= count[SLOT_W-1:0];
    end
  end

endmodule

// ===== tb/transaction_table_tid_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transaction_table_tid_allocator_tb
// Self-checking bench for the transaction table. Requests are queued up
// front by a directed sequence followed by phased random traffic: fill
// phases, drain phases, and phases that crowd one subscriber. A clocked
// driver sends them with random idle bursts. A clocked monitor stalls the
// reply side at random and compares every reply with a shadow table that is
// updated on each accepted request.
// ----------------------------------------------------------------------------
module transaction_table_tid_allocator_tb;
  import ttta_pkg::*;

  localparam int RANDOM_OPS = 640;
  localparam int PHASE_LEN  = 40;
  localparam int ID_MOD     = 7;
  localparam int ID_FLAG    = 8;

  typedef struct packed {
    logic                hold;   // wait for all replies before sending
    kind_t               kind;
    logic [SUB_W-1:0]    sub;
    logic [PROTO_W-1:0]  proto;
    tid_t                tid;
    logic                tas;
    logic [CREF_W-1:0]   cref;
    logic                flag;
    slot_t               slot;
  } table_req_t;

  typedef struct packed {
    status_t             status;
    slot_t               slot;
    tid_t                tid;
    logic                tas;
    logic [CREF_W-1:0]   cref;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // request side; all payload ports follow live_req, which changes only at a clock edge
  table_req_t          live_req  = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  kind_t               kind;
  logic [SUB_W-1:0]    subscriber;
  logic [PROTO_W-1:0]  protocol;
  tid_t                tid;
  logic                tid_assigned;
  logic [CREF_W-1:0]   call_reference;
  logic                flag_side;
  slot_t               slot;

  // reply side
  logic                out_valid;
  logic                out_ready = 1'b0;
  status_t             status;
  slot_t               found_slot;
  tid_t                result_tid;
  logic                result_tid_assigned;
  logic [CREF_W-1:0]   result_call_reference;

  assign kind           = live_req.kind;
  assign subscriber     = live_req.sub;
  assign protocol       = live_req.proto;
  assign tid            = live_req.tid;
  assign tid_assigned   = live_req.tas;
  assign call_reference = live_req.cref;
  assign flag_side      = live_req.flag;
  assign slot           = live_req.slot;

  transaction_table_tid_allocator dut (
    .clk                   (clk),
    .rst                   (rst),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .kind                  (kind),
    .subscriber            (subscriber),
    .protocol              (protocol),
    .tid                   (tid),
    .tid_assigned          (tid_assigned),
    .call_reference        (call_reference),
    .flag_side             (flag_side),
    .slot                  (slot),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .status                (status),
    .found_slot            (found_slot),
    .result_tid            (result_tid),
    .result_tid_assigned   (result_tid_assigned),
    .result_call_reference (result_call_reference)
  );

  always #2 clk = ~clk;

  table_req_t   request_q [$];   // requests not yet sent
  table_reply_t reply_q [$];     // replies owed by the block, oldest first

  // shadow copy of the table
  logic               ent_valid [ENTRIES];
  logic [SUB_W-1:0]   ent_sub   [ENTRIES];
  logic [PROTO_W-1:0] ent_proto [ENTRIES];
  tid_t               ent_tid   [ENTRIES];
  logic               ent_tas   [ENTRIES];
  logic [CREF_W-1:0]  ent_cref  [ENTRIES];
  int                 ent_rank  [ENTRIES];   // 0 = oldest
  int                 ent_count;

  int  accepted   = 0;
  int  checked    = 0;
  int  fail_cnt   = 0;
  int  gap_left   = 0;
  int  stall_left = 0;
  logic calm      = 1'b0;   // no idling on either side near the end

  function automatic table_reply_t entry_reply(input int s);
    table_reply_t rep;
    rep.status = ST_OK;
    rep.slot   = slot_t'(s);
    rep.tid    = ent_tid[s];
    rep.tas    = ent_tas[s];
    rep.cref   = ent_cref[s];
    return rep;
  endfunction

  // Work out the reply to one accepted request and apply its effect on the
  // shadow table. Every request, reserved codes included, owes one reply.
  task automatic predict_reply(input table_req_t r);
    table_reply_t rep;
    int best;
    int s;
    int h;
    int i;
    int j;
    int flag;
    int gone;
    logic [15:0] used;
    logic hit;
    rep  = '0;
    best = -1;
    case (r.kind)
      K_FIND_ID, K_FIND_REF: begin
        // oldest matching entry answers, not the lowest slot
        for (s = 0; s < ENTRIES; s++) begin
          if (r.kind == K_FIND_ID)
            hit = ent_sub[s] == r.sub && ent_proto[s] == r.proto &&
                  ent_tas[s] == r.tas && (!r.tas || ent_tid[s] == r.tid);
          else
            hit = ent_cref[s] == r.cref;
          if (ent_valid[s] && hit && (best < 0 || ent_rank[s] < ent_rank[best]))
            best = s;
        end
        if (best >= 0) rep = entry_reply(best);
        else rep.status = ST_NOT_FOUND;
      end
      K_ALLOC: begin
        for (s = ENTRIES - 1; s >= 0; s--)
          if (!ent_valid[s]) best = s;
        if (best < 0) begin
          rep.status = ST_FULL;
        end else begin
          ent_valid[best] = 1'b1;
          ent_sub[best]   = r.sub;
          ent_proto[best] = r.proto;
          ent_tid[best]   = r.tid;
          ent_tas[best]   = r.tas;
          ent_cref[best]  = r.cref;
          ent_rank[best]  = ent_count;
          ent_count++;
          rep = entry_reply(best);
        end
      end
      K_FREE: begin
        if (!ent_valid[r.slot]) begin
          rep.status = ST_UNUSED;
          rep.slot   = r.slot;
        end else begin
          rep  = entry_reply(int'(r.slot));
          gone = ent_rank[r.slot];
          ent_valid[r.slot] = 1'b0;
          // close the gap so ranks stay 0 .. count-1
          for (s = 0; s < ENTRIES; s++)
            if (ent_valid[s] && ent_rank[s] > gone) ent_rank[s]--;
          if (ent_count > 0) ent_count--;
        end
      end
      K_ASSIGN: begin
        flag = r.flag ? ID_FLAG : 0;
        used = '0;
        for (s = 0; s < ENTRIES; s++)
          if (ent_valid[s] && ent_sub[s] == r.sub && ent_proto[s] == r.proto && ent_tas[s])
            used[ent_tid[s]] = 1'b1;
        // resume after the highest id in use on this side
        h = int'(ID_TOP);
        while (h > 0 && !used[h | flag]) h--;
        rep.status = ST_NO_ID;
        for (i = 0; i < ID_MOD; i++) begin
          j = ((h + i) % ID_MOD) | flag;
          if (!used[j] && rep.status == ST_NO_ID) begin
            rep.status = ST_OK;
            rep.tid    = tid_t'(j);
            rep.tas    = 1'b1;
          end
        end
      end
      default: rep.status = ST_NOT_FOUND;   // reserved codes are ignored
    endcase
    reply_q.push_back(rep);
  endtask

  task automatic push_req(input kind_t k, input logic [SUB_W-1:0] sub,
                          input logic [PROTO_W-1:0] proto, input tid_t t,
                          input logic tas, input logic [CREF_W-1:0] cref,
                          input logic flag, input slot_t s);
    table_req_t r;
    r.hold  = 1'b0;
    r.kind  = k;
    r.sub   = sub;
    r.proto = proto;
    r.tid   = t;
    r.tas   = tas;
    r.cref  = cref;
    r.flag  = flag;
    r.slot  = s;
    request_q.push_back(r);
  endtask

  // Driver: a new transfer is offered once the previous one is taken. Idle
  // bursts follow some transfers; a hold request waits for an empty reply
  // queue first.
  always @(posedge clk) begin : drive_requests
    table_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      calm <= (request_q.size() < 80);
      if (in_valid && in_ready) begin
        predict_reply(live_req);
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0 &&
                     (!request_q[0].hold || reply_q.size() == 0)) begin
          nxt = request_q.pop_front();
          live_req <= nxt;
          in_valid <= 1'b1;
          // idle rate cycles 0 / 25 / 50 percent so some stretches run flat out
          if (!calm && $urandom_range(0, 99) < ((accepted / 64) % 3) * 25)
            gap_left <= $urandom_range(1, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each reply transfer with the oldest expectation and
  // stalls out_ready in bursts.
  always @(posedge clk) begin : check_replies
    table_reply_t want;
    table_reply_t got;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {status, found_slot, result_tid, result_tid_assigned, result_call_reference};
        if (reply_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected reply: st=%0d slot=%0d tid=%0d tas=%0b cref=%h",
                     got.status, got.slot, got.tid, got.tas, got.cref);
        end else begin
          want = reply_q.pop_front();
          checked++;
          if (got.status !== want.status || got.slot !== want.slot ||
              got.tid !== want.tid || got.tas !== want.tas || got.cref !== want.cref) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display({"reply %0d mismatch: exp st=%0d slot=%0d tid=%0d tas=%0b cref=%h,",
                        " got st=%0d slot=%0d tid=%0d tas=%0b cref=%h"},
                       checked, want.status, want.slot, want.tid, want.tas, want.cref,
                       got.status, got.slot, got.tid, got.tas, got.cref);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < ((checked / 48) % 3) * 25) begin
        stall_left <= $urandom_range(0, 5);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [SUB_W-1:0]   sub_pool   [4];
    logic [PROTO_W-1:0] proto_pool [3];
    logic [CREF_W-1:0]  cref_pool  [8];
    logic [SUB_W-1:0]   dsub;
    logic [PROTO_W-1:0] dproto;
    logic [CREF_W-1:0]  twin_ref;
    kind_t k;
    int n_ops;
    int phase;
    int r;
    int t;
    int wait_cnt;
    logic fill;
    logic focus;
    logic focus_flag;

    sub_pool   = '{16'h0000, 16'hFFFF, 16'h1234, 16'h00C3};
    proto_pool = '{4'd0, 4'd15, 4'd6};
    cref_pool  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h1234_5678,
                   32'h7FFF_FFFE, 32'hA5A5_5A5A, 32'h0000_00FF, 32'hDEAD_0042};
    dsub     = 16'h2B2B;
    dproto   = 4'd9;
    twin_ref = 32'hA5A5_5A5A;

    for (t = 0; t < ENTRIES; t++) begin
      ent_valid[t] = 1'b0;
      ent_sub[t]   = '0;
      ent_proto[t] = '0;
      ent_tid[t]   = '0;
      ent_tas[t]   = 1'b0;
      ent_cref[t]  = '0;
      ent_rank[t]  = 0;
    end
    ent_count = 0;

    // empty table: misses, free of an unused slot, first ids on both sides
    push_req(K_FIND_ID, 16'hFFFF, 4'd15, 4'd15, 1'b1, '0, 1'b0, '0);
    push_req(K_FIND_REF, '0, '0, '0, 1'b0, 32'hFFFF_FFFF, 1'b0, '0);
    push_req(K_FREE, '0, '0, '0, 1'b0, '0, 1'b0, 4'd15);
    push_req(K_ASSIGN, dsub, dproto, '0, 1'b0, '0, 1'b0, '0);
    push_req(K_ASSIGN, dsub, dproto, '0, 1'b0, '0, 1'b1, '0);
    // all-ones entry in slot 0, all-zero unassigned entry in slot 1
    push_req(K_ALLOC, 16'hFFFF, 4'd15, 4'd15, 1'b1, 32'hFFFF_FFFF, 1'b1, 4'd15);
    push_req(K_ALLOC, '0, '0, '0, 1'b0, '0, 1'b0, '0);
    // ids 0..6 in slots 2..8 use up the unflagged side
    for (t = 0; t < ID_MOD; t++)
      push_req(K_ALLOC, dsub, dproto, tid_t'(t), 1'b1, 32'h100 + t, 1'b0, '0);
    push_req(K_ASSIGN, dsub, dproto, '0, 1'b0, '0, 1'b0, '0);   // no free id
    push_req(K_ASSIGN, dsub, dproto, '0, 1'b0, '0, 1'b1, '0);   // flagged side free
    // free id 2 after the sender drains; search wraps from 6 past 0 and 1
    push_req(K_FREE, '0, '0, '0, 1'b0, '0, 1'b0, 4'd4);
    request_q[$].hold = 1'b1;
    push_req(K_ASSIGN, dsub, dproto, '0, 1'b0, '0, 1'b0, '0);
    push_req(K_FIND_ID, dsub, dproto, 4'd3, 1'b1, '0, 1'b0, '0);
    push_req(K_FIND_ID, '0, '0, 4'd9, 1'b0, '0, 1'b0, '0);      // unassigned ignores tid
    push_req(K_FIND_REF, '0, '0, '0, 1'b0, 32'hFFFF_FFFF, 1'b0, '0);
    // same call reference in slot 4 (older) and slot 1 (younger)
    push_req(K_ALLOC, 16'h00C3, 4'd1, 4'd7, 1'b1, twin_ref, 1'b0, '0);
    push_req(K_FREE, '0, '0, '0, 1'b0, '0, 1'b0, 4'd1);
    push_req(K_ALLOC, 16'h00C3, 4'd1, 4'd8, 1'b1, twin_ref, 1'b0, '0);
    push_req(K_FIND_REF, '0, '0, '0, 1'b0, twin_ref, 1'b0, '0);

    // Random part in phases: fill phases push the table to full, drain
    // phases free it; every other fill phase crowds one subscriber and
    // protocol on one side so the id search runs out of ids.
    n_ops = 0;
    while (n_ops < RANDOM_OPS) begin
      phase      = n_ops / PHASE_LEN;
      fill       = (phase % 2 == 0);
      focus      = (phase % 4 == 2);
      focus_flag = 1'((phase / 4) % 2);
      r = $urandom_range(0, 99);
      if (fill)
        k = r < 50 ? K_ALLOC : r < 62 ? K_FIND_ID : r < 72 ? K_FIND_REF :
            r < 85 ? K_ASSIGN : r < 95 ? K_FREE : kind_t'($urandom_range(5, 7));
      else
        k = r < 45 ? K_FREE : r < 55 ? K_ALLOC : r < 68 ? K_FIND_ID :
            r < 78 ? K_FIND_REF : r < 94 ? K_ASSIGN : kind_t'($urandom_range(5, 7));
      if (focus)
        push_req(k, 16'h1234, 4'd6, {focus_flag, 3'($urandom_range(0, 6))}, 1'b1,
                 ($urandom_range(0, 9) < 7) ? cref_pool[$urandom_range(0, 7)] : $urandom,
                 focus_flag, slot_t'($urandom));
      else
        push_req(k,
                 ($urandom_range(0, 9) < 8) ? sub_pool[$urandom_range(0, 3)] : 16'($urandom),
                 ($urandom_range(0, 9) < 8) ? proto_pool[$urandom_range(0, 2)] : 4'($urandom),
                 tid_t'($urandom), $urandom_range(0, 99) < 85,
                 ($urandom_range(0, 9) < 7) ? cref_pool[$urandom_range(0, 7)] : $urandom,
                 1'($urandom), slot_t'($urandom));
      if ($urandom_range(0, 99) == 0) request_q[$].hold = 1'b1;
      if (k <= K_ASSIGN) n_ops++;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() > 0 || in_valid) @(posedge clk);
    wait_cnt = 0;
    while (reply_q.size() > 0 && wait_cnt < 2000) begin
      @(posedge clk);
      wait_cnt++;
    end
    // room for any stray reply
    repeat (40) @(posedge clk);

    if (fail_cnt == 0 && reply_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
